// ===== rtl/core/bwsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Blit word datapath package
// Shared constants, configuration register indexes and control structs.
// ----------------------------------------------------------------------------
package bwsl_pkg;

    // Width of a shift amount register.
    localparam int SHIFT_BITS = 4;

    // Width of the minterm truth table: one bit per {a, b, c} combination.
    localparam int TABLE_BITS = 8;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_A_SHIFT        = 3'd0,
        REG_B_SHIFT        = 3'd1,
        REG_LOGIC_TABLE    = 3'd2,
        REG_DESCENDING     = 3'd3,
        REG_FILL_ENABLE    = 3'd4,
        REG_EXCLUSIVE_FILL = 3'd5,
        REG_FILL_CARRY_IN  = 3'd6
    } cfg_reg_t;

    // Fill controls handed from the top level to the logic stage.
    typedef struct packed {
        logic fill_enable;
        logic exclusive_fill;
        logic carry_in;
    } fill_ctrl_t;

endpackage

// ===== rtl/core/bwsl_funnel.sv =====
// ----------------------------------------------------------------------------
// Funnel shifter
// Joins a new word with the previous one and shifts right (ascending) or
// left (descending), keeping one word of the result.
// ----------------------------------------------------------------------------
module bwsl_funnel #(
    parameter int WORD_BITS = 16
) (
    input  logic [WORD_BITS-1:0]            fresh,
    input  logic [WORD_BITS-1:0]            prior,
    input  logic [bwsl_pkg::SHIFT_BITS-1:0] shift,
    input  logic                            descending,
    output logic [WORD_BITS-1:0]            result
);

    logic [2*WORD_BITS-1:0] asc_cat;
    logic [2*WORD_BITS-1:0] desc_cat;

    // Shifts past one word pull zeros in from beyond the previous word.
    always_comb
    begin
        asc_cat  = {prior, fresh} >> shift;
        desc_cat = {fresh, prior} << shift;
        if (descending)
        begin
            result = desc_cat[2*WORD_BITS-1:WORD_BITS];
        end
        else
        begin
            result = asc_cat[WORD_BITS-1:0];
        end
    end

endmodule

// ===== rtl/core/bwsl_logic.sv =====
// ----------------------------------------------------------------------------
// Minterm logic and area fill
// Applies the minterm truth table bit by bit, then the optional area fill
// from the low bit up, and reports the carry after the word.
// ----------------------------------------------------------------------------
module bwsl_logic #(
    parameter int WORD_BITS = 16
) (
    input  logic [WORD_BITS-1:0]            a_shifted,
    input  logic [WORD_BITS-1:0]            b_shifted,
    input  logic [WORD_BITS-1:0]            c_word,
    input  logic [bwsl_pkg::TABLE_BITS-1:0] logic_table,
    input  bwsl_pkg::fill_ctrl_t            fill_ctrl,
    output logic [WORD_BITS-1:0]            d_word,
    output logic                            carry_out
);

    logic [WORD_BITS-1:0] minterm_word;
    logic [WORD_BITS-1:0] carry_before;
    logic [WORD_BITS-1:0] filled;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            minterm_word[i] = logic_table[{a_shifted[i], b_shifted[i], c_word[i]}];
        end
    end

    // The carry ahead of each bit is the incoming carry toggled by every set
    // bit below it, so each bit is a parity over a masked word.
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            carry_before[i] = fill_ctrl.carry_in
                            ^ (^(minterm_word & ((WORD_BITS'(1) << i) - WORD_BITS'(1))));
            if (fill_ctrl.exclusive_fill)
            begin
                filled[i] = minterm_word[i] ^ carry_before[i];
            end
            else
            begin
                filled[i] = minterm_word[i] | carry_before[i];
            end
        end
    end

    always_comb
    begin
        if (fill_ctrl.fill_enable)
        begin
            d_word    = filled;
            carry_out = fill_ctrl.carry_in ^ (^minterm_word);
        end
        else
        begin
            d_word    = minterm_word;
            carry_out = fill_ctrl.carry_in;
        end
    end

endmodule

// ===== rtl/core/blit_word_shift_logic_fill.sv =====
// ----------------------------------------------------------------------------
// Blit word shift, logic and fill
// One request carries an A, B and C source word; one result carries the
// destination word and the fill carry after it.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes a request at a clock edge where in_valid is high
// and in_stall is low. The request is held in an input register; once the
// result register is free or being emptied it passes through the shifters,
// the minterm table and the area fill and lands in the result register,
// which raises out_valid. One request is taken every cycle while the
// receiver keeps out_stall low.
// The previous A and B words and the fill carry advance as each request
// moves into the result register, so back-to-back requests see the state
// left by the one before them.
// When out_stall is high the result register holds its word and the input
// register can still take one more request; only when both are full does
// in_stall rise.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, one register per cycle, while no request is in flight.
// Reset clears the configuration, the previous words, the fill carry and
// both valid flags.
// ----------------------------------------------------------------------------
module blit_word_shift_logic_fill #(
    parameter int WORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [bwsl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bwsl_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [WORD_BITS-1:0]                a_word,
    input  logic [WORD_BITS-1:0]                b_word,
    input  logic [WORD_BITS-1:0]                c_word,
    input  logic                                row_start,
    input  logic                                blit_start,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [WORD_BITS-1:0]                d_word,
    output logic                                carry_out
);

    // Configuration registers.
    logic [bwsl_pkg::SHIFT_BITS-1:0] a_shift_reg;
    logic [bwsl_pkg::SHIFT_BITS-1:0] b_shift_reg;
    logic [bwsl_pkg::TABLE_BITS-1:0] logic_table_reg;
    logic                            descending_reg;
    logic                            fill_enable_reg;
    logic                            exclusive_fill_reg;
    logic                            fill_carry_in_reg;

    // Input register.
    logic                 in_valid_reg;
    logic [WORD_BITS-1:0] a_word_reg;
    logic [WORD_BITS-1:0] b_word_reg;
    logic [WORD_BITS-1:0] c_word_reg;
    logic                 row_start_reg;
    logic                 blit_start_reg;

    // Running state carried from word to word.
    logic [WORD_BITS-1:0] a_previous_reg;
    logic [WORD_BITS-1:0] b_previous_reg;
    logic                 fill_carry_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] d_word_reg;
    logic                 carry_out_reg;

    logic                 in_take;
    logic                 advance;
    logic [WORD_BITS-1:0] a_prior;
    logic [WORD_BITS-1:0] b_prior;
    logic [WORD_BITS-1:0] a_shifted;
    logic [WORD_BITS-1:0] b_shifted;
    logic [WORD_BITS-1:0] d_word_next;
    logic                 carry_out_next;
    bwsl_pkg::fill_ctrl_t fill_ctrl;

    // The held request moves on whenever the result register is free or
    // being emptied this cycle; the input side stalls only when it cannot.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_shift_reg        <= '0;
            b_shift_reg        <= '0;
            logic_table_reg    <= '0;
            descending_reg     <= 1'b0;
            fill_enable_reg    <= 1'b0;
            exclusive_fill_reg <= 1'b0;
            fill_carry_in_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (bwsl_pkg::cfg_reg_t'(cfg_index))
                bwsl_pkg::REG_A_SHIFT:
                    a_shift_reg <= cfg_data[bwsl_pkg::SHIFT_BITS-1:0];
                bwsl_pkg::REG_B_SHIFT:
                    b_shift_reg <= cfg_data[bwsl_pkg::SHIFT_BITS-1:0];
                bwsl_pkg::REG_LOGIC_TABLE:
                    logic_table_reg <= cfg_data[bwsl_pkg::TABLE_BITS-1:0];
                bwsl_pkg::REG_DESCENDING:
                    descending_reg <= cfg_data[0];
                bwsl_pkg::REG_FILL_ENABLE:
                    fill_enable_reg <= cfg_data[0];
                bwsl_pkg::REG_EXCLUSIVE_FILL:
                    exclusive_fill_reg <= cfg_data[0];
                bwsl_pkg::REG_FILL_CARRY_IN:
                    fill_carry_in_reg <= cfg_data[0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Input register: valid flag under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_word_reg     <= a_word;
            b_word_reg     <= b_word;
            c_word_reg     <= c_word;
            row_start_reg  <= row_start;
            blit_start_reg <= blit_start;
        end
    end

    // A blit start joins the new words with zero; a row start reloads the
    // fill carry before the fill runs.
    assign a_prior = blit_start_reg ? '0 : a_previous_reg;
    assign b_prior = blit_start_reg ? '0 : b_previous_reg;

    assign fill_ctrl.fill_enable    = fill_enable_reg;
    assign fill_ctrl.exclusive_fill = exclusive_fill_reg;
    assign fill_ctrl.carry_in       = row_start_reg ? fill_carry_in_reg : fill_carry_reg;

    bwsl_funnel #(
        .WORD_BITS (WORD_BITS)
    ) u_a_funnel (
        .fresh      (a_word_reg),
        .prior      (a_prior),
        .shift      (a_shift_reg),
        .descending (descending_reg),
        .result     (a_shifted)
    );

    bwsl_funnel #(
        .WORD_BITS (WORD_BITS)
    ) u_b_funnel (
        .fresh      (b_word_reg),
        .prior      (b_prior),
        .shift      (b_shift_reg),
        .descending (descending_reg),
        .result     (b_shifted)
    );

    bwsl_logic #(
        .WORD_BITS (WORD_BITS)
    ) u_logic (
        .a_shifted   (a_shifted),
        .b_shifted   (b_shifted),
        .c_word      (c_word_reg),
        .logic_table (logic_table_reg),
        .fill_ctrl   (fill_ctrl),
        .d_word      (d_word_next),
        .carry_out   (carry_out_next)
    );

    // Running state advances together with the result register, so the
    // next request in the input register sees what this one left behind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_previous_reg <= '0;
            b_previous_reg <= '0;
            fill_carry_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_previous_reg <= a_word_reg;
            b_previous_reg <= b_word_reg;
            fill_carry_reg <= carry_out_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_word_reg    <= d_word_next;
            carry_out_reg <= carry_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign d_word    = d_word_reg;
    assign carry_out = carry_out_reg;

endmodule

// ===== rtl/core/bwsl_checker.sv =====
// ----------------------------------------------------------------------------
// Blit word datapath port checker
// Watches the top level's ports for stall, latency and hold behavior.
// ----------------------------------------------------------------------------
module bwsl_checker #(
    parameter int WORD_BITS = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [WORD_BITS-1:0] a_word,
    input logic [WORD_BITS-1:0] b_word,
    input logic [WORD_BITS-1:0] c_word,
    input logic                 row_start,
    input logic                 blit_start,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [WORD_BITS-1:0] d_word,
    input logic                 carry_out
);

    // A stalled result keeps its valid flag and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(d_word) && $stable(carry_out))
    else $error("stalled result changed");

    // A stalled request stays offered with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid
            && $stable({a_word, b_word, c_word, row_start, blit_start}))
    else $error("stalled request changed");

    // The input side only stalls when the result side is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side could move");

    // An accepted request must be followed by a valid result on the output side.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
    else $error("accepted request did not reach the result register");

endmodule

bind blit_word_shift_logic_fill bwsl_checker #(
    .WORD_BITS (WORD_BITS)
) u_bwsl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .a_word     (a_word),
    .b_word     (b_word),
    .c_word     (c_word),
    .row_start  (row_start),
    .blit_start (blit_start),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .d_word     (d_word),
    .carry_out  (carry_out)
);

// ===== tb/blit_word_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit word result checker
// Follows the configuration port and the request and result channels of
// the blit word datapath. It computes the destination word and fill carry
// of every accepted request, queues them, and compares each accepted
// result against the oldest queued one.
// ----------------------------------------------------------------------------
module blit_word_checker #(
    parameter int WORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [bwsl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bwsl_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [WORD_BITS-1:0]                a_word,
    input  logic [WORD_BITS-1:0]                b_word,
    input  logic [WORD_BITS-1:0]                c_word,
    input  logic                                row_start,
    input  logic                                blit_start,

    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [WORD_BITS-1:0]                d_word,
    input  logic                                carry_out,

    output int                                  mismatches,
    output int                                  pending
);

    localparam int SHIFT_BITS = bwsl_pkg::SHIFT_BITS;
    localparam int TABLE_BITS = bwsl_pkg::TABLE_BITS;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 carry;
    } dest_t;

    // Register copies.
    logic [SHIFT_BITS-1:0] shift_a;
    logic [SHIFT_BITS-1:0] shift_b;
    logic [TABLE_BITS-1:0] minterms;
    logic                  desc_mode;
    logic                  fill_on;
    logic                  fill_xor;
    logic                  carry_seed;

    // Datapath state as the block should hold it.
    logic [WORD_BITS-1:0]  a_last;
    logic [WORD_BITS-1:0]  b_last;
    logic                  fill_carry;

    dest_t                 dest_due[$];
    int                    fail_count;

    assign mismatches = fail_count;

    // Ascending takes the window [s+W-1:s] of {previous, new}; descending
    // takes [2W-1-s:W-s] of {new, previous}.
    function automatic logic [WORD_BITS-1:0] funnel_shift(
        input logic [WORD_BITS-1:0]  fresh,
        input logic [WORD_BITS-1:0]  prior,
        input logic [SHIFT_BITS-1:0] amount,
        input logic                  desc
    );
        logic [2*WORD_BITS-1:0] joined;
        if (desc)
        begin
            joined = {fresh, prior} << amount;
            return joined[2*WORD_BITS-1:WORD_BITS];
        end
        joined = {prior, fresh} >> amount;
        return joined[WORD_BITS-1:0];
    endfunction

    function automatic dest_t predict_dest(
        input logic [WORD_BITS-1:0] a_new,
        input logic [WORD_BITS-1:0] b_new,
        input logic [WORD_BITS-1:0] c_new,
        input logic                 row,
        input logic                 blit
    );
        logic [WORD_BITS-1:0] a_sh;
        logic [WORD_BITS-1:0] b_sh;
        logic [WORD_BITS-1:0] mixed;
        logic [WORD_BITS-1:0] filled;
        logic                 cy;
        dest_t                res;
        if (blit)
        begin
            a_last = '0;
            b_last = '0;
        end
        if (row)
            fill_carry = carry_seed;
        a_sh = funnel_shift(a_new, a_last, shift_a, desc_mode);
        b_sh = funnel_shift(b_new, b_last, shift_b, desc_mode);
        for (int i = 0; i < WORD_BITS; i++)
            mixed[i] = minterms[{a_sh[i], b_sh[i], c_new[i]}];
        filled = mixed;
        if (fill_on)
        begin
            cy = fill_carry;
            for (int i = 0; i < WORD_BITS; i++)
            begin
                filled[i] = fill_xor ? (mixed[i] ^ cy) : (mixed[i] | cy);
                cy = cy ^ mixed[i];
            end
            fill_carry = cy;
        end
        a_last = a_new;
        b_last = b_new;
        res.word  = filled;
        res.carry = fill_carry;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dest_t exp_res;
        if (!rst_n)
        begin
            shift_a    = '0;
            shift_b    = '0;
            minterms   = '0;
            desc_mode  = 1'b0;
            fill_on    = 1'b0;
            fill_xor   = 1'b0;
            carry_seed = 1'b0;
            a_last     = '0;
            b_last     = '0;
            fill_carry = 1'b0;
            dest_due.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    bwsl_pkg::REG_A_SHIFT:        shift_a    = cfg_data[SHIFT_BITS-1:0];
                    bwsl_pkg::REG_B_SHIFT:        shift_b    = cfg_data[SHIFT_BITS-1:0];
                    bwsl_pkg::REG_LOGIC_TABLE:    minterms   = cfg_data[TABLE_BITS-1:0];
                    bwsl_pkg::REG_DESCENDING:     desc_mode  = cfg_data[0];
                    bwsl_pkg::REG_FILL_ENABLE:    fill_on    = cfg_data[0];
                    bwsl_pkg::REG_EXCLUSIVE_FILL: fill_xor   = cfg_data[0];
                    bwsl_pkg::REG_FILL_CARRY_IN:  carry_seed = cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (dest_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result at %0t: d_word %h carry_out %b",
                                 $time, d_word, carry_out);
                end
                else
                begin
                    exp_res = dest_due.pop_front();
                    if (d_word !== exp_res.word || carry_out !== exp_res.carry)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch at %0t: d_word %h exp %h, carry_out %b exp %b",
                                     $time, d_word, exp_res.word, carry_out,
                                     exp_res.carry);
                    end
                end
            end

            if (in_valid && !in_stall)
                dest_due.push_back(predict_dest(a_word, b_word, c_word,
                                                row_start, blit_start));

            pending <= dest_due.size();
        end
    end

endmodule

// ===== tb/blit_word_shift_logic_fill_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit word shift, logic and fill testbench
// Drives requests of A, B and C words through the blit datapath under a
// series of register settings, with random gaps on the request side and
// random stalls on the result side, and lets a separate checker compare
// every result with its own computation.
// ----------------------------------------------------------------------------
module blit_word_shift_logic_fill_tb;

    localparam int WORD_BITS      = 16;
    localparam int SHIFT_BITS     = bwsl_pkg::SHIFT_BITS;
    localparam int TABLE_BITS     = bwsl_pkg::TABLE_BITS;
    localparam int CFG_INDEX_BITS = bwsl_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = bwsl_pkg::CFG_DATA_BITS;
    // Cycles without any handshake before the run is declared hung. The
    // longest legal quiet stretch is a long random stall or gap at the
    // heaviest idling, plus the settle time at a settings change.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_SEG  = 95;
    localparam int SEGS_PER_PHASE = 6;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;

    logic                      cfg_write  = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic [WORD_BITS-1:0]      a_word     = '0;
    logic [WORD_BITS-1:0]      b_word     = '0;
    logic [WORD_BITS-1:0]      c_word     = '0;
    logic                      row_start  = 1'b0;
    logic                      blit_start = 1'b0;

    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic [WORD_BITS-1:0]      d_word;
    logic                      carry_out;

    int                        mismatches;
    int                        pending;

    // Idle rates in percent, changed by the stimulus between phases.
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    int                        quiet_cycles  = 0;

    always #5 clk = ~clk;

    blit_word_shift_logic_fill #(
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_word     (a_word),
        .b_word     (b_word),
        .c_word     (c_word),
        .row_start  (row_start),
        .blit_start (blit_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .d_word     (d_word),
        .carry_out  (carry_out)
    );

    blit_word_checker #(
        .WORD_BITS (WORD_BITS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .a_word     (a_word),
        .b_word     (b_word),
        .c_word     (c_word),
        .row_start  (row_start),
        .blit_start (blit_start),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .d_word     (d_word),
        .carry_out  (carry_out),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // The result side stalls at random, one fresh draw per cycle. With a
    // rate of zero it never stalls.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Any accepted request or result counts as progress. A long stretch
    // without either means the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("blit_word_shift_logic_fill test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One register write per clock edge. The caller lowers cfg_write after
    // the last write of a group, so back-to-back writes keep it high.
    task automatic write_reg(
        input bwsl_pkg::cfg_reg_t        idx,
        input logic [CFG_DATA_BITS-1:0] value
    );
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes the full register set. Only called while nothing is in flight.
    task automatic load_settings(
        input logic [SHIFT_BITS-1:0] a_sh,
        input logic [SHIFT_BITS-1:0] b_sh,
        input logic [TABLE_BITS-1:0] minterm_bits,
        input logic                  desc,
        input logic                  fill,
        input logic                  excl,
        input logic                  seed
    );
        write_reg(bwsl_pkg::REG_A_SHIFT,        CFG_DATA_BITS'(a_sh));
        write_reg(bwsl_pkg::REG_B_SHIFT,        CFG_DATA_BITS'(b_sh));
        write_reg(bwsl_pkg::REG_LOGIC_TABLE,    minterm_bits);
        write_reg(bwsl_pkg::REG_DESCENDING,     CFG_DATA_BITS'(desc));
        write_reg(bwsl_pkg::REG_FILL_ENABLE,    CFG_DATA_BITS'(fill));
        write_reg(bwsl_pkg::REG_EXCLUSIVE_FILL, CFG_DATA_BITS'(excl));
        write_reg(bwsl_pkg::REG_FILL_CARRY_IN,  CFG_DATA_BITS'(seed));
        cfg_write <= 1'b0;
    endtask

    // Presents one request and returns at the edge where it is taken. The
    // random gap ahead of it drops valid; otherwise valid stays high from
    // the previous request so there is only one assignment per edge. The
    // payload is left alone while the block stalls.
    task automatic send_request(
        input logic [WORD_BITS-1:0] a,
        input logic [WORD_BITS-1:0] b,
        input logic [WORD_BITS-1:0] c,
        input logic                 row,
        input logic                 blit
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        a_word     <= a;
        b_word     <= b;
        c_word     <= c;
        row_start  <= row;
        blit_start <= blit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops sending and waits until every outstanding result has come back,
    // then lets the two-stage pipeline settle before anything else happens.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Shift amounts lean on the two ends of the range.
    function automatic logic [SHIFT_BITS-1:0] pick_shift();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return SHIFT_BITS'($urandom_range(0, 15));
        endcase
    endfunction

    // A mix of the classic tables (all clear, all set, pass A, pass B,
    // pass C, three-way XOR, cookie cut) and random ones.
    function automatic logic [TABLE_BITS-1:0] pick_minterms();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'hF0;
            3:       return 8'hCC;
            4:       return 8'hAA;
            5:       return 8'h96;
            6:       return 8'hCA;
            default: return TABLE_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Sparse words matter for the fill, since a dense word just toggles the
    // carry back and forth; the ends of the range show up too.
    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return WORD_BITS'($urandom & $urandom & $urandom);
            default: return WORD_BITS'($urandom);
        endcase
    endfunction

    // Sends a stream shaped like real blits: the first request starts a blit
    // and a row, rows run a few words each, and now and then a row also
    // starts a fresh blit. About one request in ten carries random flags.
    task automatic run_segment(input int count);
        int   row_left;
        logic row;
        logic blit;
        row_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n == 0)
            begin
                row      = 1'b1;
                blit     = 1'b1;
                row_left = $urandom_range(1, 8);
            end
            else if (row_left == 0)
            begin
                row      = 1'b1;
                blit     = ($urandom_range(0, 5) == 0);
                row_left = $urandom_range(1, 8);
            end
            else
            begin
                row  = 1'b0;
                blit = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                row  = 1'($urandom_range(0, 1));
                blit = 1'($urandom_range(0, 1));
            end
            row_left--;
            send_request(pick_word(), pick_word(), pick_word(), row, blit);
        end
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part and the first random phase run with a lightly
        // idling sender and a heavily stalling receiver.
        send_idle_pct = 16;
        recv_idle_pct = 86;

        // Source A passed straight through, ascending, no fill. The first
        // request starts a blit, so the previous words are cleared.
        load_settings(4'd0, 4'd0, 8'hF0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_request(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_request(16'hAAAA, 16'h5555, 16'h0F0F, 1'b0, 1'b0);
        wait_idle();

        // Largest ascending shift on A with a three-way AND. The third
        // request restarts the blit so the old A and B words must vanish.
        load_settings(4'd15, 4'd1, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
        send_request(16'h8001, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_request(16'h1234, 16'hABCD, 16'hFFFF, 1'b0, 1'b1);
        wait_idle();

        // Descending mode: shifts go left and pull in the top of the
        // previous word. Table is A or (B and C).
        load_settings(4'd15, 4'd7, 8'hF8, 1'b1, 1'b0, 1'b0, 1'b0);
        send_request(16'hFFFF, 16'h8000, 16'hFFFF, 1'b1, 1'b1);
        send_request(16'h0001, 16'h0001, 16'hFFFF, 1'b0, 1'b0);
        send_request(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
        wait_idle();

        // Inclusive fill on source C. The carry must survive from one word
        // to the next and be reloaded with zero on a row start.
        load_settings(4'd0, 4'd0, 8'hAA, 1'b0, 1'b1, 1'b0, 1'b0);
        send_request(16'h0000, 16'h0000, 16'h0810, 1'b1, 1'b1);
        send_request(16'h0000, 16'h0000, 16'h8000, 1'b0, 1'b0);
        send_request(16'h0000, 16'h0000, 16'h0001, 1'b0, 1'b0);
        send_request(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        send_request(16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
        wait_idle();

        // Exclusive fill starting each row with the carry set.
        load_settings(4'd0, 4'd0, 8'hAA, 1'b0, 1'b1, 1'b1, 1'b1);
        send_request(16'h0000, 16'h0000, 16'h0810, 1'b1, 1'b1);
        send_request(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_request(16'h0000, 16'h0000, 16'h8001, 1'b1, 1'b0);
        wait_idle();

        // Fill off: the carry is only reloaded by a row start and reported
        // as it stands.
        load_settings(4'd0, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_request(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        wait_idle();

        // Random part: three idling phases, each a handful of segments
        // under fresh random settings.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 86;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGS_PER_PHASE; seg++)
            begin
                load_settings(pick_shift(), pick_shift(), pick_minterms(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                run_segment(ITEMS_PER_SEG);
                wait_idle();
            end
        end

        // Give a late, unexpected result a chance to show up.
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("blit_word_shift_logic_fill test passed");
        else
            $display("blit_word_shift_logic_fill test failed");
        $finish;
    end

endmodule

// ===== blit_word_shift_logic_fill.f =====
rtl/core/bwsl_pkg.sv
rtl/core/bwsl_funnel.sv
rtl/core/bwsl_logic.sv
rtl/core/blit_word_shift_logic_fill.sv
rtl/core/bwsl_checker.sv
tb/blit_word_checker.sv
tb/blit_word_shift_logic_fill_tb.sv
